/* hw/rtl/tpb_pkg.sv */
package tpb_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COEF_W     = 32;
   localparam int CFG_DATA_W = 64;
   localparam int CFG_REGS   = 6;
   localparam int CFG_ADDR_W = 6;
   localparam int CFG_IDX_LSB = 3;
   localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_IDX_LSB;

   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int DIST_W   = 64;
   localparam int ROOT_W   = 32;
   localparam int RADIUS_W = 31;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_X_XY = 3'd0,
      REG_X_ZT = 3'd1,
      REG_Y_XY = 3'd2,
      REG_Y_ZT = 3'd3,
      REG_Z_XY = 3'd4,
      REG_Z_ZT = 3'd5
   } cfg_reg_type;

endpackage

/* hw/rtl/tpb_req_if.sv */
interface tpb_req_if
   import tpb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vert_x;
   logic signed [COORD_BITS-1:0] vert_y;
   logic signed [COORD_BITS-1:0] vert_z;
   logic                         final_vertex;

   modport source (output valid, vert_x, vert_y, vert_z, final_vertex, input ready);
   modport sink   (input valid, vert_x, vert_y, vert_z, final_vertex, output ready);
endinterface

/* hw/rtl/tpb_rsp_if.sv */
interface tpb_rsp_if
   import tpb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] box_min_x;
   logic signed [COORD_BITS-1:0] box_min_y;
   logic signed [COORD_BITS-1:0] box_min_z;
   logic signed [COORD_BITS-1:0] box_max_x;
   logic signed [COORD_BITS-1:0] box_max_y;
   logic signed [COORD_BITS-1:0] box_max_z;
   logic signed [COORD_BITS-1:0] mid_x;
   logic signed [COORD_BITS-1:0] mid_y;
   logic signed [COORD_BITS-1:0] mid_z;
   logic [RADIUS_W-1:0]          bound_radius;
   logic                         updated;

   modport source (
      output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
             mid_x, mid_y, mid_z, bound_radius, updated,
      input  ready
   );
   modport sink (
      input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
             mid_x, mid_y, mid_z, bound_radius, updated,
      output ready
   );
endinterface

/* hw/rtl/tpb_isqrt.sv */
module tpb_isqrt
   import tpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIST_W-1:0]   value,
   output logic                done,
   output logic [ROOT_W-1:0]   root
);

   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIST_W-1:0] val_ff, val_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] shifted;
   logic [ROOT_W+1:0] trial;

   // one result bit per cycle, restoring digit recurrence
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      shifted = {rem_ff[ROOT_W-1:0], val_ff[DIST_W-1:DIST_W-2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[DIST_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hw/rtl/transformed_point_bounds_unit.sv */
// Each vertex item is accepted, run through the 3 axes in turn on one shared 33x33
// multiplier, then used for the update; a last vertex of a mesh with two or more
// vertices then runs the bit-serial square root before the result item.
// A new vertex item is accepted only in idle, once the previous one is done.
// Reset: synchronous, active high; identity matrix, empty mesh, no result pending.
module transformed_point_bounds_unit
   import tpb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tpb_req_if.sink               req_chan,
   tpb_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CFG_ADDR_W-1:0] paddr,
   input  logic [CFG_DATA_W-1:0] pwdata,
   output logic [CFG_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int HALF  = (COORD_BITS + 1) / 2;
   localparam int ACC_W = (COORD_BITS + 34 > PROD_W) ? COORD_BITS + 34 : PROD_W;
   localparam int MAG_W = (COORD_BITS > MUL_W) ? COORD_BITS : MUL_W;
   localparam int MAG_X = MAG_W + 1;
   localparam int MID_W = COORD_BITS + 1;
   localparam logic [COEF_W-1:0]     COEF_ONE  = COEF_W'(1) << FRAC_BITS;
   localparam logic [COORD_BITS-1:0] CMAX      = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] CMIN      = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [2:0]            LAST_PART = 3'd5;
   localparam logic [1:0]            LAST_AXIS = 2'd2;
   localparam logic [1:0]            SEEN_MAX  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_DRAIN, ST_FIN, ST_SQ, ST_SQACC, ST_UPD, ST_ROOT, ST_EMIT
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   state_type                state_ff, state_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [1:0]               axis_ff, axis_in;
   logic                     pend_ff, pend_in;
   logic                     pend_hi_ff, pend_hi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   coord_type                vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic                     fin_ff, fin_in;
   coord_type                p_ff, p_in;
   logic                     big_ff, big_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [DIST_W-1:0]        peak_ff, peak_in;
   logic [1:0]               seen_ff, seen_in;
   coord_type                low_ff [3];
   coord_type                low_in [3];
   coord_type                high_ff [3];
   coord_type                high_in [3];
   logic                     ok_ff, ok_in;
   logic [CFG_DATA_W-1:0]    cfg_ff [CFG_REGS];
   logic [CFG_DATA_W-1:0]    cfg_in [CFG_REGS];

   logic                     rsp_valid_ff, rsp_valid_in;
   coord_type                out_lo_ff [3];
   coord_type                out_lo_in [3];
   coord_type                out_hi_ff [3];
   coord_type                out_hi_in [3];
   coord_type                out_mid_ff [3];
   coord_type                out_mid_in [3];
   logic [RADIUS_W-1:0]      out_rad_ff, out_rad_in;
   logic                     out_upd_ff, out_upd_in;

   logic [CFG_DATA_W-1:0]    row_xy, row_zt;
   logic [COEF_W-1:0]        coef;
   coord_type                coord;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic signed [ACC_W-1:0]  prod_ext, acc_term, acc_sh, acc_sum;
   logic [ACC_W-COORD_BITS:0] acc_top;
   coord_type                p_new;
   logic signed [MAG_W:0]    p_ext, p_abs;
   logic [MAG_W-1:0]         mag;
   logic [DIST_W-1:0]        sq_val;
   logic [DIST_W:0]          dist_sum;
   logic [DIST_W-1:0]        peak_new;
   logic [1:0]               seen_inc;
   logic signed [MID_W-1:0]  mid_sum [3];
   logic                     accept, rsp_free, cfg_wr;
   logic [CFG_IDX_W-1:0]     cfg_idx;
   logic                     root_start, root_done;
   logic [ROOT_W-1:0]        root_val;

   tpb_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (peak_new),
      .done  (root_done),
      .root  (root_val)
   );

   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign cfg_idx  = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
   assign cfg_wr   = psel && penable && pwrite;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            row_xy = cfg_ff[REG_X_XY];
            row_zt = cfg_ff[REG_X_ZT];
         end
         2'd1: begin
            row_xy = cfg_ff[REG_Y_XY];
            row_zt = cfg_ff[REG_Y_ZT];
         end
         default: begin
            row_xy = cfg_ff[REG_Z_XY];
            row_zt = cfg_ff[REG_Z_ZT];
         end
      endcase
      case (cnt_ff[2:1])
         2'd0: begin
            coef  = row_xy[COEF_W-1:0];
            coord = vx_ff;
         end
         2'd1: begin
            coef  = row_xy[CFG_DATA_W-1:COEF_W];
            coord = vy_ff;
         end
         default: begin
            coef  = row_zt[COEF_W-1:0];
            coord = vz_ff;
         end
      endcase
   end

   // shared multiplier operands: coefficient x coordinate half, or |p| squared
   always_comb begin
      p_ext = MAG_X'(p_ff);
      p_abs = p_ext[MAG_W] ? -p_ext : p_ext;
      mag   = p_abs[MAG_W-1:0];
      if (state_ff == ST_SQ) begin
         mul_a = MUL_W'(mag[31:0]);
         mul_b = MUL_W'(mag[31:0]);
      end else begin
         mul_a = MUL_W'($signed(coef));
         if (cnt_ff[0]) begin
            mul_b = MUL_W'($signed(coord[COORD_BITS-1:HALF]));
         end else begin
            mul_b = MUL_W'(coord[HALF-1:0]);
         end
      end
      mul_prod = mul_a * mul_b;
   end

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      acc_term = pend_hi_ff ? (prod_ext <<< HALF) : prod_ext;
      acc_sh   = acc_ff >>> FRAC_BITS;
      acc_sum  = acc_sh + ACC_W'($signed(row_zt[CFG_DATA_W-1:COEF_W]));
      acc_top  = acc_sum[ACC_W-1:COORD_BITS-1];
      if ((&acc_top) || !(|acc_top)) begin
         p_new = acc_sum[COORD_BITS-1:0];
      end else begin
         p_new = acc_sum[ACC_W-1] ? CMIN : CMAX;
      end
      sq_val   = big_ff ? '1 : prod_ff[DIST_W-1:0];
      dist_sum = {1'b0, dist_ff} + {1'b0, sq_val};
      peak_new = ((seen_ff == 2'd0) || (dist_ff > peak_ff)) ? dist_ff : peak_ff;
      seen_inc = (seen_ff == SEEN_MAX) ? SEEN_MAX : seen_ff + 1'b1;
      for (int i = 0; i < 3; i++) begin
         mid_sum[i] = MID_W'(low_ff[i]) + MID_W'(high_ff[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      pend_in      = 1'b0;
      pend_hi_in   = pend_hi_ff;
      prod_in      = prod_ff;
      acc_in       = pend_ff ? acc_ff + acc_term : acc_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      fin_in       = fin_ff;
      p_in         = p_ff;
      big_in       = big_ff;
      dist_in      = dist_ff;
      peak_in      = peak_ff;
      seen_in      = seen_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      ok_in        = ok_ff;
      cfg_in       = cfg_ff;
      root_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_lo_in    = out_lo_ff;
      out_hi_in    = out_hi_ff;
      out_mid_in   = out_mid_ff;
      out_rad_in   = out_rad_ff;
      out_upd_in   = out_upd_ff;

      if (cfg_wr && (cfg_idx <= REG_Z_ZT)) begin
         cfg_in[cfg_idx] = pwdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               vx_in    = req_chan.vert_x;
               vy_in    = req_chan.vert_y;
               vz_in    = req_chan.vert_z;
               fin_in   = req_chan.final_vertex;
               cnt_in   = '0;
               axis_in  = '0;
               acc_in   = '0;
               dist_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in    = mul_prod;
            pend_in    = 1'b1;
            pend_hi_in = cnt_ff[0];
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_PART) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            p_in   = p_new;
            acc_in = '0;
            if (seen_ff == 2'd0) begin
               low_in[axis_ff]  = p_new;
               high_in[axis_ff] = p_new;
            end else begin
               if (p_new < low_ff[axis_ff]) begin
                  low_in[axis_ff] = p_new;
               end
               if (p_new > high_ff[axis_ff]) begin
                  high_in[axis_ff] = p_new;
               end
            end
            state_in = ST_SQ;
         end
         ST_SQ: begin
            prod_in  = mul_prod;
            big_in   = |mag[MAG_W-1:32];
            state_in = ST_SQACC;
         end
         ST_SQACC: begin
            dist_in = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
            if (axis_ff == LAST_AXIS) begin
               state_in = ST_UPD;
            end else begin
               axis_in  = axis_ff + 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_UPD: begin
            if (fin_ff) begin
               seen_in = '0;
               peak_in = '0;
               if (seen_inc == SEEN_MAX) begin
                  root_start = 1'b1;
                  state_in   = ST_ROOT;
               end else begin
                  ok_in    = 1'b0;
                  state_in = ST_EMIT;
               end
            end else begin
               seen_in  = seen_inc;
               peak_in  = peak_new;
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               ok_in    = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_upd_in   = ok_ff;
               for (int i = 0; i < 3; i++) begin
                  out_lo_in[i]  = ok_ff ? low_ff[i] : '0;
                  out_hi_in[i]  = ok_ff ? high_ff[i] : '0;
                  out_mid_in[i] = ok_ff ? mid_sum[i][MID_W-1:1] : '0;
               end
               if (!ok_ff) begin
                  out_rad_in = '0;
               end else if (root_val[ROOT_W-1]) begin
                  out_rad_in = '1;
               end else begin
                  out_rad_in = root_val[RADIUS_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         seen_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff[REG_X_XY] <= CFG_DATA_W'(COEF_ONE);
         cfg_ff[REG_X_ZT] <= '0;
         cfg_ff[REG_Y_XY] <= {COEF_ONE, {COEF_W{1'b0}}};
         cfg_ff[REG_Y_ZT] <= '0;
         cfg_ff[REG_Z_XY] <= '0;
         cfg_ff[REG_Z_ZT] <= CFG_DATA_W'(COEF_ONE);
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         seen_ff      <= seen_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      cnt_ff     <= cnt_in;
      axis_ff    <= axis_in;
      pend_hi_ff <= pend_hi_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      vz_ff      <= vz_in;
      fin_ff     <= fin_in;
      p_ff       <= p_in;
      big_ff     <= big_in;
      dist_ff    <= dist_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      ok_ff      <= ok_in;
      out_lo_ff  <= out_lo_in;
      out_hi_ff  <= out_hi_in;
      out_mid_ff <= out_mid_in;
      out_rad_ff <= out_rad_in;
      out_upd_ff <= out_upd_in;
   end

   always_comb begin
      case (cfg_idx)
         REG_X_XY: prdata = cfg_ff[REG_X_XY];
         REG_X_ZT: prdata = cfg_ff[REG_X_ZT];
         REG_Y_XY: prdata = cfg_ff[REG_Y_XY];
         REG_Y_ZT: prdata = cfg_ff[REG_Y_ZT];
         REG_Z_XY: prdata = cfg_ff[REG_Z_XY];
         REG_Z_ZT: prdata = cfg_ff[REG_Z_ZT];
         default:  prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.box_min_x    = out_lo_ff[0];
   assign rsp_chan.box_min_y    = out_lo_ff[1];
   assign rsp_chan.box_min_z    = out_lo_ff[2];
   assign rsp_chan.box_max_x    = out_hi_ff[0];
   assign rsp_chan.box_max_y    = out_hi_ff[1];
   assign rsp_chan.box_max_z    = out_hi_ff[2];
   assign rsp_chan.mid_x        = out_mid_ff[0];
   assign rsp_chan.mid_y        = out_mid_ff[1];
   assign rsp_chan.mid_z        = out_mid_ff[2];
   assign rsp_chan.bound_radius = out_rad_ff;
   assign rsp_chan.updated      = out_upd_ff;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

import tpb_pkg::*;

localparam int CW  = COORD_BITS_DEF;
localparam int FB  = FRAC_BITS_DEF;
localparam int ONE = 1 << FB;

typedef logic signed [CW-1:0] coord_type;

localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};
localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};
localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

// unmapped register slots, writes there are dropped
localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

typedef struct packed {
   coord_type [2:0]     box_min;
   coord_type [2:0]     box_max;
   coord_type [2:0]     mid;
   logic [RADIUS_W-1:0] radius;
   logic                updated;
} bounds_type;

class bounds_scoreboard;
   logic [CFG_DATA_W-1:0] matrix_regs [CFG_REGS];
   int unsigned           seen;
   coord_type             low_c [3];
   coord_type             high_c [3];
   logic [DIST_W-1:0]     peak_sq;
   bounds_type            expected_q [$];
   int unsigned           errors, vertices, full_meshes, short_meshes, checked;

   function new();
      for (int i = 0; i < CFG_REGS; i++) matrix_regs[i] = '0;
      matrix_regs[REG_X_XY] = {32'd0, 32'(ONE)};
      matrix_regs[REG_Y_XY] = {32'(ONE), 32'd0};
      matrix_regs[REG_Z_ZT] = {32'd0, 32'(ONE)};
      seen    = 0;
      peak_sq = '0;
   endfunction

   task report(string msg);
      $display("tb_top: mismatch: %s", msg);
      errors++;
   endtask

   function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx < CFG_REGS) matrix_regs[idx] = val;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // exact products, floor to FB fraction bits, add shift, clamp to coord range
   function coord_type map_axis(int axis, coord_type vx, coord_type vy, coord_type vz);
      logic signed [127:0] acc, cx, cy, cz, shift, top, bot;
      cx    = $signed(matrix_regs[2*axis][31:0]);
      cy    = $signed(matrix_regs[2*axis][63:32]);
      cz    = $signed(matrix_regs[2*axis+1][31:0]);
      shift = $signed(matrix_regs[2*axis+1][63:32]);
      acc   = cx * vx + cy * vy + cz * vz;
      acc   = (acc >>> FB) + shift;
      top   = (128'sd1 <<< (CW-1)) - 128'sd1;
      bot   = -top - 128'sd1;
      if (acc > top) acc = top;
      else if (acc < bot) acc = bot;
      return coord_type'(acc[CW-1:0]);
   endfunction

   function logic [31:0] int_sqrt(logic [DIST_W-1:0] v);
      logic [63:0] root, trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root[31:0];
   endfunction

   function void note_vertex(coord_type vx, coord_type vy, coord_type vz, logic last);
      coord_type              p [3];
      logic signed [DIST_W:0] ps;
      logic [DIST_W+1:0]      sum;
      logic signed [CW:0]     s;
      logic [31:0]            root;
      bounds_type             want;
      sum = '0;
      vertices++;
      for (int a = 0; a < 3; a++) begin
         p[a] = map_axis(a, vx, vy, vz);
         ps   = p[a];
         sum  = sum + ps * ps;
      end
      if (sum > {DIST_W{1'b1}}) sum = {DIST_W{1'b1}};
      if (seen == 0) begin
         for (int a = 0; a < 3; a++) begin
            low_c[a]  = p[a];
            high_c[a] = p[a];
         end
         peak_sq = sum[DIST_W-1:0];
      end else begin
         for (int a = 0; a < 3; a++) begin
            if (p[a] < low_c[a]) low_c[a] = p[a];
            if (p[a] > high_c[a]) high_c[a] = p[a];
         end
         if (sum[DIST_W-1:0] > peak_sq) peak_sq = sum[DIST_W-1:0];
      end
      if (seen < 2) seen++;
      if (!last) return;

      want = '0;
      if (seen >= 2) begin
         for (int a = 0; a < 3; a++) begin
            s = low_c[a] + high_c[a];
            want.box_min[a] = low_c[a];
            want.box_max[a] = high_c[a];
            want.mid[a]     = coord_type'(s >>> 1);
         end
         root = int_sqrt(peak_sq);
         want.radius  = (root > RADIUS_MAX) ? RADIUS_MAX : root[RADIUS_W-1:0];
         want.updated = 1'b1;
         full_meshes++;
      end else begin
         short_meshes++;
      end
      expected_q.insert(expected_q.size(), want);
      seen    = 0;
      peak_sq = '0;
   endfunction

   task check_result(bounds_type got);
      bounds_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected result item %h", got));
         return;
      end
      want = expected_q.pop_front();
      for (int a = 0; a < 3; a++) begin
         if (got.box_min[a] !== want.box_min[a])
            report($sformatf("result %0d box_min[%0d] got %h want %h",
                             checked, a, got.box_min[a], want.box_min[a]));
         if (got.box_max[a] !== want.box_max[a])
            report($sformatf("result %0d box_max[%0d] got %h want %h",
                             checked, a, got.box_max[a], want.box_max[a]));
         if (got.mid[a] !== want.mid[a])
            report($sformatf("result %0d mid[%0d] got %h want %h",
                             checked, a, got.mid[a], want.mid[a]));
      end
      if (got.radius !== want.radius)
         report($sformatf("result %0d bound_radius got %h want %h",
                          checked, got.radius, want.radius));
      if (got.updated !== want.updated)
         report($sformatf("result %0d updated got %b want %b",
                          checked, got.updated, want.updated));
      checked++;
   endtask
endclass

module tb_top;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 55;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CFG_ADDR_W-1:0] paddr;
   logic [CFG_DATA_W-1:0] pwdata;
   logic [CFG_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned sender_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned idle_cycles;
   int unsigned csr_writes;

   bounds_scoreboard sb = new();

   tpb_req_if #(.COORD_BITS(CW)) req_chan ();
   tpb_rsp_if #(.COORD_BITS(CW)) rsp_chan ();

   transformed_point_bounds_unit #(
      .COORD_BITS(CW),
      .FRAC_BITS (FB)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bounds_type grab_result();
      bounds_type r;
      r.box_min = {rsp_chan.box_min_z, rsp_chan.box_min_y, rsp_chan.box_min_x};
      r.box_max = {rsp_chan.box_max_z, rsp_chan.box_max_y, rsp_chan.box_max_x};
      r.mid     = {rsp_chan.mid_z, rsp_chan.mid_y, rsp_chan.mid_x};
      r.radius  = rsp_chan.bound_radius;
      r.updated = rsp_chan.updated;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_result(grab_result());
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: watchdog expired, %0d results outstanding", sb.pending());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, val);
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic send_vertex(coord_type vx, coord_type vy, coord_type vz, logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.vert_x       <= vx;
      req_chan.vert_y       <= vy;
      req_chan.vert_z       <= vz;
      req_chan.final_vertex <= last;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_vertex(vx, vy, vz, last);
   endtask

   // idle the input, let every result come back and the last vertex finish
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               3: return -1;
               default: return coord_type'(ONE);
            endcase
         end
         1, 2: return coord_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_DATA_W-1:0] identity_reg(int idx);
      case (idx)
         REG_X_XY: return {32'd0, 32'(ONE)};
         REG_Y_XY: return {32'(ONE), 32'd0};
         REG_Z_ZT: return {32'd0, 32'(ONE)};
         default:  return '0;
      endcase
   endfunction

   function automatic logic [31:0] small_coef();
      return 32'($urandom_range(0, 4 * ONE)) - 32'(2 * ONE);
   endfunction

   task automatic apply_setting(int ph);
      logic [CFG_DATA_W-1:0] val;
      for (int i = 0; i < CFG_REGS; i++) begin
         case (ph)
            1: val = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2: val = {32'h8000_0000, 32'h8000_0000};
            3: val = (i % 2) ? {$urandom, 32'd0} : '0;
            4: val = (i % 2) ? {32'($urandom_range(0, 255) << FB), small_coef()}
                             : {small_coef(), small_coef()};
            6: val = identity_reg(i) | ((i % 2) ? {32'h7FFF_FFFF, 32'd0} : '0);
            7: val = identity_reg(i);
            default: val = {$urandom, $urandom};
         endcase
         csr_write(cfg_reg_type'(i), val);
      end
      if (ph == 4) begin
         csr_write(REG_SPARE_A, {$urandom, $urandom});
         csr_write(REG_SPARE_B, '1);
      end
   endtask

   task automatic run_meshes(int quota);
      int sent, len;
      sent = 0;
      while (sent < quota) begin
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
         for (int k = 0; k < len; k++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
         sent += len;
      end
   endtask

   task automatic run_directed();
      send_vertex('0, '0, '0, 1'b1);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      send_vertex(1, -1, 0, 1'b0);
      send_vertex(-1, 1, 0, 1'b0);
      send_vertex(0, 0, -1, 1'b1);
      send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      for (int k = 0; k < 4; k++)
         send_vertex(7 * ONE, -3 * ONE, ONE, k == 3);
   endtask

   initial begin
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.vert_x       <= '0;
      req_chan.vert_y       <= '0;
      req_chan.vert_z       <= '0;
      req_chan.final_vertex <= 1'b0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      csr_writes      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         apply_setting(ph);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin sender_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         run_meshes(PHASE_ITEMS);
      end
      settle();

      $display("tb_top: %0d vertices, %0d meshes with a box, %0d single-vertex meshes",
               sb.vertices, sb.full_meshes, sb.short_meshes);
      $display("tb_top: %0d matrix settings over %0d register writes, %0d results checked",
               PHASES + 1, csr_writes, sb.checked);
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
